FILE: rtl/cpxbs_pkg.sv
// shared types, constants and microprogram for the charlieplex bar and servo sequencer
package cpxbs_pkg;

  localparam int SLOT_COUNT    = 12;
  localparam int LED_COUNT     = 6;
  localparam int BAR_GAIN      = 6;
  localparam int SERVO_GAIN    = 37;
  localparam int SERVO_STEP    = 50;
  localparam int SERVO_BASE    = 650;
  localparam int SERVO_MAX     = 2500;
  localparam int SERVO_PRELOAD = (SERVO_MAX - SERVO_BASE) / 2;
  localparam int DIV_BIAS      = 511;

  localparam logic [2:0] CPX0 = 3'b001;
  localparam logic [2:0] CPX1 = 3'b010;
  localparam logic [2:0] CPX2 = 3'b100;

  localparam logic [2:0] POS_PIN [8] = '{CPX0, CPX1, CPX1, CPX2, CPX0, CPX2, 3'b000, 3'b000};
  localparam logic [2:0] NEG_PIN [8] = '{CPX1, CPX0, CPX2, CPX1, CPX2, CPX0, 3'b000, 3'b000};

  typedef struct packed {
    logic       action;
    logic [9:0] adc_sample;
  } cpxbs_in_t;

  typedef struct packed {
    logic [2:0]  led_pin_level;
    logic [2:0]  led_pin_drive;
    logic [11:0] servo_pulse_us;
    logic        servo_running;
  } cpxbs_out_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_TOGGLE,
    OP_ACC_BAR,
    OP_LATCH_BAR,
    OP_ACC_SERVO,
    OP_LATCH_TARGET,
    OP_SCAN,
    OP_COPY
  } op_t;

  typedef enum logic {
    JMP_NONE,
    JMP_SERVO_OFF
  } jmp_t;

  typedef logic [2:0] upc_t;

  typedef struct packed {
    op_t  op;
    logic advance;
    logic last;
    jmp_t jmp;
    upc_t target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic advance;
    logic load;
  } dp_ctrl_t;

  typedef struct packed {
    logic [3:0] slot_index;
    logic       servo_enabled;
  } dp_status_t;

  // program entry points
  localparam upc_t UPC_BUTTON    = 3'd0;
  localparam upc_t UPC_MEASURE   = 3'd1;
  localparam upc_t UPC_SERVO     = 3'd3;
  localparam upc_t UPC_SCAN      = 3'd5;
  localparam upc_t UPC_COPY      = 3'd6;
  localparam upc_t UPC_IDLE_SLOT = 3'd7;

  function automatic uword_t ucode(input upc_t addr);
    uword_t w;
    w = '{op: OP_NOP, advance: 1'b1, last: 1'b1, jmp: JMP_NONE, target: UPC_BUTTON};
    case (addr)
      3'd0: w = '{op: OP_TOGGLE, advance: 1'b0, last: 1'b1, jmp: JMP_NONE, target: UPC_BUTTON};
      3'd1: w = '{op: OP_ACC_BAR, advance: 1'b0, last: 1'b0, jmp: JMP_NONE, target: UPC_BUTTON};
      3'd2: w = '{op: OP_LATCH_BAR, advance: 1'b0, last: 1'b0, jmp: JMP_SERVO_OFF,
                  target: UPC_IDLE_SLOT};
      3'd3: w = '{op: OP_ACC_SERVO, advance: 1'b0, last: 1'b0, jmp: JMP_NONE, target: UPC_BUTTON};
      3'd4: w = '{op: OP_LATCH_TARGET, advance: 1'b1, last: 1'b1, jmp: JMP_NONE,
                  target: UPC_BUTTON};
      3'd5: w = '{op: OP_SCAN, advance: 1'b1, last: 1'b1, jmp: JMP_NONE, target: UPC_BUTTON};
      3'd6: w = '{op: OP_COPY, advance: 1'b1, last: 1'b1, jmp: JMP_NONE, target: UPC_BUTTON};
      3'd7: w = '{op: OP_NOP, advance: 1'b1, last: 1'b1, jmp: JMP_NONE, target: UPC_BUTTON};
      default: w = '{op: OP_NOP, advance: 1'b1, last: 1'b1, jmp: JMP_NONE, target: UPC_BUTTON};
    endcase
    return w;
  endfunction

  // x / 1023 as (x + x/1024 + 1) / 1024, exact while the quotient stays below 64
  function automatic logic [5:0] div1023(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {11'd0, x[15:10]} + 17'd1;
    return t[15:10];
  endfunction

endpackage

FILE: rtl/cpxbs_datapath.sv
// datapath: schedule state, scaling arithmetic, led scan and servo registers
module cpxbs_datapath #(
  parameter int LED_COUNT  = cpxbs_pkg::LED_COUNT,
  parameter int SLOT_COUNT = cpxbs_pkg::SLOT_COUNT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cpxbs_pkg::dp_ctrl_t  ctrl,
  input  logic [9:0]           sample_in,
  output cpxbs_pkg::dp_status_t status,
  output cpxbs_pkg::cpxbs_out_t result
);
  import cpxbs_pkg::*;

  logic [3:0]  slot_index;
  logic [2:0]  led_index;
  logic [2:0]  bar_level;
  logic [11:0] servo_target;
  logic        servo_enabled;
  logic [11:0] servo_compare;
  logic [2:0]  pin_level_reg;
  logic [2:0]  pin_drive_reg;
  logic [15:0] acc;
  logic [9:0]  sample;
  logic [5:0]  quo;

  assign quo = div1023(acc);

  // payload registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sample <= sample_in;
    end
    case (ctrl.op)
      OP_ACC_BAR:   acc <= {6'd0, sample} * 16'(BAR_GAIN) + 16'(DIV_BIAS);
      OP_ACC_SERVO: acc <= {6'd0, sample} * 16'(SERVO_GAIN) + 16'(DIV_BIAS);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_index    <= '0;
      led_index     <= '0;
      bar_level     <= '0;
      servo_target  <= '0;
      servo_enabled <= 1'b0;
      servo_compare <= '0;
      pin_level_reg <= '0;
      pin_drive_reg <= '0;
    end else begin
      case (ctrl.op)
        OP_TOGGLE: begin
          if (!servo_enabled) begin
            servo_enabled <= 1'b1;
            servo_compare <= 12'(SERVO_PRELOAD);
          end else begin
            servo_enabled <= 1'b0;
          end
        end
        OP_LATCH_BAR: bar_level <= quo[2:0];
        OP_LATCH_TARGET: servo_target <= {6'd0, quo} * 12'(SERVO_STEP) + 12'(SERVO_BASE);
        OP_SCAN: begin
          if (bar_level > led_index) begin
            pin_level_reg <= POS_PIN[led_index];
            pin_drive_reg <= POS_PIN[led_index] | NEG_PIN[led_index];
          end else begin
            pin_level_reg <= '0;
            pin_drive_reg <= '0;
          end
          led_index <= (led_index >= 3'(LED_COUNT - 1)) ? 3'd0 : led_index + 3'd1;
        end
        OP_COPY: begin
          if (servo_enabled) begin
            servo_compare <= servo_target;
          end
        end
        default: ;
      endcase
      if (ctrl.advance) begin
        slot_index <= (slot_index >= 4'(SLOT_COUNT - 1)) ? 4'd0 : slot_index + 4'd1;
      end
    end
  end

  assign status.slot_index    = slot_index;
  assign status.servo_enabled = servo_enabled;

  assign result.led_pin_level  = pin_level_reg;
  assign result.led_pin_drive  = pin_drive_reg;
  assign result.servo_pulse_us = servo_compare;
  assign result.servo_running  = servo_enabled;

endmodule

FILE: rtl/charlieplex_bar_and_servo_sequencer_core.sv
// top level: microcoded sequencer driving the bar display and servo datapath
// Each accepted item starts a short microprogram picked from the item type and the
// current schedule slot; the block holds item_ready low while it runs and takes the
// next item in the cycle after the last step. A button press or any tick outside
// slot 0 runs a single step; a slot 0 tick runs 3 steps with the servo off and 4
// with it on (two constant scalings, each a registered multiply-add followed by a
// divide-by-1023 step). The visible result lives in the datapath registers themselves:
// the last step of an item, which is the only one that touches them, waits while a
// result is still waiting to be taken.
module charlieplex_bar_and_servo_sequencer_core #(
  parameter int LED_COUNT  = cpxbs_pkg::LED_COUNT,
  parameter int SLOT_COUNT = cpxbs_pkg::SLOT_COUNT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  cpxbs_pkg::cpxbs_in_t   item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output cpxbs_pkg::cpxbs_out_t  result
);
  import cpxbs_pkg::*;

  logic       busy;
  upc_t       upc;
  upc_t       upc_next;
  upc_t       entry;
  uword_t     uw;
  logic       step;
  logic       accept;
  dp_ctrl_t   ctrl;
  dp_status_t status;

  assign item_ready = !busy;
  assign accept     = item_valid && item_ready;
  assign uw         = ucode(upc);
  // final step updates the visible registers, so hold it while a result waits
  assign step       = busy && !(uw.last && result_valid && !result_ready);

  always_comb begin
    if (item.action) begin
      entry = UPC_BUTTON;
    end else if (status.slot_index == 4'd0) begin
      entry = UPC_MEASURE;
    end else if (status.slot_index[0]) begin
      entry = UPC_SCAN;
    end else if (status.slot_index == 4'd2) begin
      entry = UPC_COPY;
    end else begin
      entry = UPC_IDLE_SLOT;
    end
  end

  always_comb begin
    if (uw.jmp == JMP_SERVO_OFF && !status.servo_enabled) begin
      upc_next = uw.target;
    end else begin
      upc_next = upc + 3'd1;
    end
  end

  assign ctrl.op      = step ? uw.op : OP_NOP;
  assign ctrl.advance = step && uw.advance;
  assign ctrl.load    = accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      upc          <= UPC_BUTTON;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        upc  <= entry;
      end else if (step) begin
        if (uw.last) begin
          busy <= 1'b0;
        end else begin
          upc <= upc_next;
        end
      end
      if (step && uw.last) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  cpxbs_datapath #(
    .LED_COUNT  (LED_COUNT),
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .sample_in (item.adc_sample),
    .status    (status),
    .result    (result)
  );

  // a stalled final step keeps its place in the program
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    busy && uw.last && result_valid && !result_ready |=> busy && $stable(upc))
    else $error("final step moved while result was waiting");

  // a new result only appears after a final step ran
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(busy && uw.last))
    else $error("result raised without a final step");

  // a program runs to its final step without dropping out
  a_program_runs: assert property (@(posedge clk) disable iff (rst)
    busy && !uw.last |=> busy)
    else $error("microprogram ended early");

  // an accepted item always starts a program
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> busy && upc == $past(entry))
    else $error("accepted item did not start at its entry point");

endmodule
